FILE: rtl/s256_pkg.sv
// Package with SHA-256 constants, types and round functions.
package s256_pkg;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef enum logic [2:0] {
		ST_FILL,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} state_t;

	typedef logic [31:0] word_t;

	function automatic word_t init_hash(input logic [2:0] idx);
		case (idx)
			3'd0: init_hash = 32'h6a09e667;
			3'd1: init_hash = 32'hbb67ae85;
			3'd2: init_hash = 32'h3c6ef372;
			3'd3: init_hash = 32'ha54ff53a;
			3'd4: init_hash = 32'h510e527f;
			3'd5: init_hash = 32'h9b05688c;
			3'd6: init_hash = 32'h1f83d9ab;
			default: init_hash = 32'h5be0cd19;
		endcase
	endfunction

	function automatic word_t round_const(input logic [5:0] idx);
		word_t k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		round_const = k[idx];
	endfunction

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

FILE: rtl/sha256_byte_stream_digest.sv
// SHA-256 over a byte stream: block store, schedule window and round datapath.
// Bytes are taken one per cycle while a block fills; the transfer that fills a block
// stalls input through the load, round and fold (chain update) states.
// An end transfer adds one padding write per cycle up to the block end and one or two
// compressions, then eight digest words, one per output transfer.
// arst_n clears control state and restores the initial chain value.
module sha256_byte_stream_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_in,
	output logic        ready_in,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        valid_out,
	input  logic        ready_out,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	s256_pkg::state_t state_q, state_d;

	logic [31:0] blk_mem [16];
	logic [31:0] w_mem [16];
	logic [31:0] chain_q [8];
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [5:0]  fill_q;
	logic [60:0] count_q;
	logic [6:0]  step_q;
	logic        pad_done_q;
	logic        padpos_ok_q;
	logic        final_q;
	logic [31:0] blk_rd_q;
	logic [2:0]  emit_q;

	logic        take;
	logic [5:0]  wr_pos;
	logic [7:0]  wr_byte;
	logic        wr_en;
	logic [63:0] bits;

	assign bits = {count_q, 3'b000};
	assign take = valid_in && ready_in;
	assign ready_in = (state_q == s256_pkg::ST_FILL);

	// Byte write into the block store, one lane of a word at a time.
	always_comb begin
		wr_en = 1'b0;
		wr_pos = fill_q;
		wr_byte = data_byte;
		if (take && byte_present) begin
			wr_en = 1'b1;
		end else if (state_q == s256_pkg::ST_PAD) begin
			wr_en = 1'b1;
			if (!pad_done_q) begin
				wr_byte = s256_pkg::PAD_BYTE;
			end else if (padpos_ok_q && fill_q >= 6'd56) begin
				wr_byte = bits[6'd63 - {fill_q[2:0], 3'b000} -: 8];
			end else begin
				wr_byte = 8'h00;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			blk_mem[wr_pos[5:2]][5'd31 - {wr_pos[1:0], 3'b000} -: 8] <= wr_byte;
		end
		blk_rd_q <= blk_mem[step_q[3:0]];
	end

	// Round datapath; schedule words are read combinationally from a 16-word window.
	logic [31:0] x15, x2, x7, x16, w_cur, t1, t2;
	always_comb begin
		x16 = w_mem[step_q[3:0]];
		x15 = w_mem[step_q[3:0] + 4'd1];
		x2  = w_mem[step_q[3:0] + 4'd14];
		x7  = w_mem[step_q[3:0] + 4'd9];
		if (step_q < 7'd16) begin
			w_cur = w_mem[step_q[3:0]];
		end else begin
			w_cur = x16 + x7
				+ (s256_pkg::rotr(x15, 7) ^ s256_pkg::rotr(x15, 18) ^ (x15 >> 3))
				+ (s256_pkg::rotr(x2, 17) ^ s256_pkg::rotr(x2, 19) ^ (x2 >> 10));
		end
		t1 = h_q + (s256_pkg::rotr(e_q, 6) ^ s256_pkg::rotr(e_q, 11) ^ s256_pkg::rotr(e_q, 25))
			+ ((e_q & f_q) ^ (~e_q & g_q)) + s256_pkg::round_const(step_q[5:0]) + w_cur;
		t2 = (s256_pkg::rotr(a_q, 2) ^ s256_pkg::rotr(a_q, 13) ^ s256_pkg::rotr(a_q, 22))
			+ ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
	end

	always_ff @(posedge clk) begin
		if (state_q == s256_pkg::ST_LOAD && step_q != 7'd0) begin
			w_mem[step_q[3:0] - 4'd1] <= blk_rd_q;
		end else if (state_q == s256_pkg::ST_ROUND && step_q >= 7'd16) begin
			w_mem[step_q[3:0]] <= w_cur;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			s256_pkg::ST_FILL: begin
				if (take) begin
					if (byte_present && fill_q == 6'd63) begin
						state_d = s256_pkg::ST_LOAD;
					end else if (end_of_message) begin
						state_d = s256_pkg::ST_PAD;
					end
				end
			end
			s256_pkg::ST_LOAD: if (step_q == 7'd16) state_d = s256_pkg::ST_ROUND;
			s256_pkg::ST_ROUND: if (step_q == 7'd63) state_d = s256_pkg::ST_FOLD;
			s256_pkg::ST_FOLD: begin
				if (!final_q) begin
					state_d = s256_pkg::ST_FILL;
				end else if (pad_done_q && padpos_ok_q) begin
					state_d = s256_pkg::ST_EMIT;
				end else begin
					state_d = s256_pkg::ST_PAD;
				end
			end
			s256_pkg::ST_PAD: if (fill_q == 6'd63) state_d = s256_pkg::ST_LOAD;
			s256_pkg::ST_EMIT: begin
				if (ready_out && emit_q == 3'd7) state_d = s256_pkg::ST_FILL;
			end
			default: state_d = s256_pkg::ST_FILL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= s256_pkg::ST_FILL;
			fill_q <= '0;
			count_q <= '0;
			step_q <= '0;
			pad_done_q <= 1'b0;
			padpos_ok_q <= 1'b0;
			final_q <= 1'b0;
			emit_q <= '0;
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
			e_q <= '0; f_q <= '0; g_q <= '0; h_q <= '0;
			for (int i = 0; i < 8; i++) chain_q[i] <= s256_pkg::init_hash(3'(i));
		end else begin
			state_q <= state_d;
			case (state_q)
				s256_pkg::ST_FILL: begin
					step_q <= '0;
					if (take) begin
						if (byte_present) begin
							fill_q <= fill_q + 6'd1;
							count_q <= count_q + 61'd1;
						end
						if (end_of_message) begin
							final_q <= 1'b1;
							pad_done_q <= 1'b0;
						end
					end
				end
				s256_pkg::ST_PAD: begin
					// Pad byte first, then zeros to the block end; length only in
					// the last eight bytes of a block that has room for it.
					pad_done_q <= 1'b1;
					fill_q <= fill_q + 6'd1;
					step_q <= '0;
					if (!pad_done_q) begin
						padpos_ok_q <= (fill_q < 6'd56);
					end
				end
				s256_pkg::ST_LOAD: begin
					step_q <= (step_q == 7'd16) ? 7'd0 : step_q + 7'd1;
					if (step_q == 7'd16) begin
						a_q <= chain_q[0]; b_q <= chain_q[1];
						c_q <= chain_q[2]; d_q <= chain_q[3];
						e_q <= chain_q[4]; f_q <= chain_q[5];
						g_q <= chain_q[6]; h_q <= chain_q[7];
					end
				end
				s256_pkg::ST_ROUND: begin
					step_q <= step_q + 7'd1;
					h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
					d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
				end
				s256_pkg::ST_FOLD: begin
					chain_q[0] <= chain_q[0] + a_q; chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q; chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q; chain_q[5] <= chain_q[5] + f_q;
					chain_q[6] <= chain_q[6] + g_q; chain_q[7] <= chain_q[7] + h_q;
					step_q <= '0;
					emit_q <= '0;
					// A pad byte at position 56 or later leaves the length for one more block.
					if (final_q && pad_done_q && !padpos_ok_q) begin
						padpos_ok_q <= 1'b1;
					end
				end
				s256_pkg::ST_EMIT: begin
					if (ready_out) begin
						emit_q <= emit_q + 3'd1;
						if (emit_q == 3'd7) begin
							for (int i = 0; i < 8; i++) begin
								chain_q[i] <= s256_pkg::init_hash(3'(i));
							end
							fill_q <= '0;
							count_q <= '0;
							final_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign valid_out = (state_q == s256_pkg::ST_EMIT);
	assign digest_word = chain_q[emit_q];
	assign word_index = emit_q;
	assign last_word = (emit_q == 3'd7);

endmodule

FILE: rtl/s256_checker.sv
// Port-level checks for the SHA-256 byte stream block, bound to the top level.
module s256_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       ready_in,
	input logic       valid_out,
	input logic       ready_out,
	input logic [2:0] word_index,
	input logic       last_word
);
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out |-> (last_word == (word_index == 3'd7))) else $error("last_word mismatch");
	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out |-> !ready_in) else $error("input open during digest");
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_out && ready_out && !last_word) |=> (valid_out && word_index == $past(word_index) + 3'd1))
		else $error("digest words out of order");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_out && !ready_out) |=> (valid_out && $stable(word_index))) else $error("output dropped");
endmodule

bind sha256_byte_stream_digest s256_checker u_chk (
	.clk(clk), .arst_n(arst_n), .ready_in(ready_in),
	.valid_out(valid_out), .ready_out(ready_out),
	.word_index(word_index), .last_word(last_word));
